@@ sv/ipv4_route_table_lookup_top_macros.svh @@
// Assertion macros shared by the route table checker
`ifndef IPV4_ROUTE_TABLE_LOOKUP_TOP_MACROS_SVH
`define IPV4_ROUTE_TABLE_LOOKUP_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define IPRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define IPRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/iprt_pkg.sv @@
// Shared types and constants for the IPv4 route table
`timescale 1ns / 1ps
`default_nettype none
package iprt_pkg;

  localparam int ADDR_W     = 32;
  localparam int INTF_ID_W  = 4;
  localparam int INTF_MAX_W = 8;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic load_out;
  } iprt_cmd_t;

  typedef struct packed {
    logic op_insert;
    logic empty;
    logic scan_last;
    logic out_free;
  } iprt_sts_t;

endpackage
`default_nettype wire

@@ sv/iprt_ctrl.sv @@
// Sequencer for insert and lookup words of the route table
`timescale 1ns / 1ps
`default_nettype none
module iprt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  iprt_pkg::iprt_sts_t    sts,
  output iprt_pkg::iprt_cmd_t    cmd
);
  import iprt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t state;

  always_comb begin
    cmd.accept   = (state == S_IDLE) && in_valid;
    cmd.rd_en    = (state == S_SCAN);
    cmd.load_out = (state == S_DONE) && sts.out_free;
    in_stall     = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            // inserts and lookups on an empty table need no walk
            if (sts.op_insert || sts.empty) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (sts.scan_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/iprt_dp.sv @@
// Route memory, match compare, best-route registers and output word register
`timescale 1ns / 1ps
`default_nettype none
module iprt_dp #(
  parameter int ENTRIES   = 16,
  parameter int INTF_BITS = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  iprt_pkg::iprt_cmd_t                    cmd,
  output iprt_pkg::iprt_sts_t                    sts,
  input  wire logic                              opcode,
  input  wire logic [iprt_pkg::ADDR_W-1:0]       address,
  input  wire logic [iprt_pkg::ADDR_W-1:0]       net_mask,
  input  wire logic [iprt_pkg::ADDR_W-1:0]       gateway_addr,
  input  wire logic [iprt_pkg::INTF_ID_W-1:0]    intf_id,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   hit,
  output logic [iprt_pkg::ADDR_W-1:0]            next_hop,
  output logic [iprt_pkg::INTF_ID_W-1:0]         out_intf,
  output logic                                   status
);
  import iprt_pkg::*;

  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int ENTRY_W = 3 * ADDR_W + INTF_BITS;

  logic [ENTRY_W-1:0]   mem [ENTRIES];
  logic [ENTRY_W-1:0]   rd_data;
  logic                 rd_valid;

  logic [CNT_W-1:0]     fill_count;
  logic [IDX_W-1:0]     scan_idx;
  logic                 full;
  logic                 wr_en;

  logic                 op_q;
  logic                 refused_q;
  logic [ADDR_W-1:0]    addr_q;

  logic                 found;
  logic [ADDR_W-1:0]    best_mask;
  logic [ADDR_W-1:0]    best_gw;
  logic [INTF_BITS-1:0] best_intf;

  logic [ADDR_W-1:0]    rd_dest;
  logic [ADDR_W-1:0]    rd_mask;
  logic [ADDR_W-1:0]    rd_gw;
  logic [INTF_BITS-1:0] rd_intf;
  logic                 take;

  logic [INTF_MAX_W-1:0] intf_in_wide;
  logic [INTF_BITS-1:0]  intf_st;
  logic [INTF_MAX_W-1:0] intf_out_wide;

  assign full  = (fill_count == CNT_W'(ENTRIES));
  assign wr_en = cmd.accept && (opcode == OP_INSERT) && !full;

  always_comb begin
    intf_in_wide = '0;
    intf_in_wide[INTF_ID_W-1:0] = intf_id;
    intf_st = intf_in_wide[INTF_BITS-1:0];
    intf_out_wide = '0;
    intf_out_wide[INTF_BITS-1:0] = best_intf;
  end

  assign rd_dest = rd_data[ENTRY_W-1 -: ADDR_W];
  assign rd_mask = rd_data[INTF_BITS + 2*ADDR_W - 1 -: ADDR_W];
  assign rd_gw   = rd_data[INTF_BITS + ADDR_W - 1 -: ADDR_W];
  assign rd_intf = rd_data[INTF_BITS-1:0];

  // strictly greater mask wins, so an earlier slot keeps a tie
  assign take = rd_valid && ((addr_q & rd_mask) == rd_dest) &&
                (!found || (rd_mask > best_mask));

  always_comb begin
    sts.op_insert = (opcode == OP_INSERT);
    sts.empty     = (fill_count == '0);
    sts.scan_last = (({1'b0, CNT_W'(scan_idx)} + (CNT_W+1)'(1)) == {1'b0, fill_count});
    sts.out_free  = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_count[IDX_W-1:0]] <= {address, net_mask, gateway_addr, intf_st};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      rd_valid   <= 1'b0;
      scan_idx   <= '0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_en;
      if (wr_en) begin
        fill_count <= fill_count + CNT_W'(1);
      end
      if (cmd.accept) begin
        scan_idx <= '0;
        found    <= 1'b0;
      end else begin
        if (cmd.rd_en) begin
          scan_idx <= scan_idx + IDX_W'(1);
        end
        if (take) begin
          found <= 1'b1;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q      <= opcode;
      refused_q <= full;
      addr_q    <= address;
    end
    if (take) begin
      best_mask <= rd_mask;
      best_gw   <= rd_gw;
      best_intf <= rd_intf;
    end
    if (cmd.load_out) begin
      if (op_q == OP_INSERT) begin
        hit      <= 1'b0;
        next_hop <= '0;
        out_intf <= '0;
        status   <= refused_q ? ST_FULL : ST_OK;
      end else begin
        hit      <= found;
        // on-link route: forward straight to the looked-up address
        next_hop <= !found ? '0 : ((best_gw != '0) ? best_gw : addr_q);
        out_intf <= found ? intf_out_wide[INTF_ID_W-1:0] : '0;
        status   <= ST_OK;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/ipv4_route_table_lookup_top.sv @@
// Top level of the IPv4 route table with longest-prefix lookup
//
//   channel | handshake           | fields
//   --------+---------------------+---------------------------------------------
//   in      | in_valid / in_stall | opcode, address, net_mask, gateway_addr, intf_id
//   out     | out_valid/out_stall | hit, next_hop, out_intf, status
//
// An insert word, or a lookup on an empty table, loads its result from the done state
// once the output is free; any other lookup first walks all stored routes, as the
// sequencer reads one stored route per cycle and compares it once it is registered.
// A result waits while the previous word is still stalled; the next input word is
// taken the cycle after the result loads, even while that result is still stalled.
// rst is synchronous; it empties the table and drops any pending result word.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_route_table_lookup_top #(
  parameter int ENTRIES   = 16,
  parameter int INTF_BITS = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              opcode,
  input  wire logic [iprt_pkg::ADDR_W-1:0]       address,
  input  wire logic [iprt_pkg::ADDR_W-1:0]       net_mask,
  input  wire logic [iprt_pkg::ADDR_W-1:0]       gateway_addr,
  input  wire logic [iprt_pkg::INTF_ID_W-1:0]    intf_id,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   hit,
  output logic [iprt_pkg::ADDR_W-1:0]            next_hop,
  output logic [iprt_pkg::INTF_ID_W-1:0]         out_intf,
  output logic                                   status
);
  import iprt_pkg::*;

  iprt_cmd_t cmd;
  iprt_sts_t sts;

  iprt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  iprt_dp #(
    .ENTRIES   (ENTRIES),
    .INTF_BITS (INTF_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (opcode),
    .address      (address),
    .net_mask     (net_mask),
    .gateway_addr (gateway_addr),
    .intf_id      (intf_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .next_hop     (next_hop),
    .out_intf     (out_intf),
    .status       (status)
  );

endmodule
`default_nettype wire

@@ sv/iprt_checker.sv @@
// Port-level checks on the route table, bound to its top level
`timescale 1ns / 1ps
`default_nettype none
`include "ipv4_route_table_lookup_top_macros.svh"
module iprt_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic                              hit,
  input wire logic [iprt_pkg::ADDR_W-1:0]       next_hop,
  input wire logic [iprt_pkg::INTF_ID_W-1:0]    out_intf,
  input wire logic                              status
);
  import iprt_pkg::*;

  // a held result word keeps its contents
  `IPRT_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(hit) && $stable(next_hop) &&
                    $stable(out_intf) && $stable(status),
                    "stalled result word changed")

  // an accepted word makes the block busy in the next cycle
  `IPRT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
                    "input taken again straight after acceptance")

  // misses and insert results carry no route
  `IPRT_ASSERT_NOW(a_miss_clear, out_valid && !hit, next_hop == '0 && out_intf == '0,
                   "miss or insert word carries route data")

  // a table-full refusal never reports a hit
  `IPRT_ASSERT_NOW(a_full_no_hit, out_valid && status == ST_FULL, !hit,
                   "refused insert reports a hit")

  // a hit always comes with an ok status
  `IPRT_ASSERT_NOW(a_hit_ok, out_valid && hit, status == ST_OK, "hit with error status")

endmodule

bind ipv4_route_table_lookup_top iprt_checker u_iprt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .hit       (hit),
  .next_hop  (next_hop),
  .out_intf  (out_intf),
  .status    (status)
);
`default_nettype wire
